### rtl/length_prefix_deframer_defines.svh
// Assertion macros for the length prefix deframer checker.
// Included by the checker file only; depends on nothing else.
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, disabled while reset is active.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

### rtl/lpd_pkg.sv
// Shared widths, codes and types of the length prefix deframer.
// No dependencies; every other file except the defines header imports this package.
`timescale 1ns / 1ps

package lpd_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'hFFFF;

	// Input operation codes.
	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// One classified result travelling from the front to the back.
	typedef struct packed {
		logic              is_err;
		logic [BYTE_W-1:0] data;
		logic              last;
	} lpd_cmd_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} lpd_qstat_t;

endpackage

### rtl/lpd_in_if.sv
// Input channel of the deframer: stream byte or restart request.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_in_if;
	import lpd_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [BYTE_W-1:0] data;

	modport source (output valid, output op, output data, input ready);
	modport sink (input valid, input op, input data, output ready);
endinterface

### rtl/lpd_out_if.sv
// Output channel of the deframer: payload byte, last marker and error flag.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_out_if;
	import lpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload;
	logic              last;
	logic              error;

	modport source (output valid, output payload, output last, output error, input ready);
	modport sink (input valid, input payload, input last, input error, output ready);
endinterface

### rtl/lpd_front.sv
// Front part: accepts requests, tracks the length prefix and frame state,
// and pushes classified results into the queue. Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	lpd_in_if.sink                    in_ch,
	input  logic                      cfg_wr_en,
	input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data,
	input  lpd_pkg::lpd_qstat_t       qstat,
	output logic                      push,
	output lpd_pkg::lpd_cmd_t         push_cmd
);
	import lpd_pkg::*;

	typedef enum logic [2:0] {
		PH_HIGH = 3'b001,
		PH_LOW  = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [BYTE_W-1:0] len_hi_q, len_hi_n;
	logic [LEN_W-1:0]  remaining_q, remaining_n;
	logic              violated_q, violated_n;
	logic [LEN_W-1:0]  max_len_q;
	logic [LEN_W-1:0]  frame_len;
	logic              accept;

	// A request is taken whenever the queue has room.
	assign in_ch.ready = !qstat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign frame_len   = {len_hi_q, in_ch.data};

	// Parse the stream and classify each accepted request.
	always_comb begin
		phase_n     = phase_q;
		len_hi_n    = len_hi_q;
		remaining_n = remaining_q;
		violated_n  = violated_q;
		push        = 1'b0;
		push_cmd    = '0;
		if (accept) begin
			if (in_ch.op == OP_RESTART) begin
				phase_n     = PH_HIGH;
				len_hi_n    = '0;
				remaining_n = '0;
				violated_n  = 1'b0;
			end else if (!violated_q) begin
				unique case (phase_q)
					PH_HIGH: begin
						len_hi_n = in_ch.data;
						phase_n  = PH_LOW;
					end
					PH_LOW: begin
						phase_n     = PH_HIGH;
						remaining_n = '0;
						if (frame_len > max_len_q) begin
							// Oversized prefix: report once, then drop until restart.
							violated_n      = 1'b1;
							push            = 1'b1;
							push_cmd.is_err = 1'b1;
						end else if (frame_len != '0) begin
							phase_n     = PH_BODY;
							remaining_n = frame_len;
						end
					end
					PH_BODY: begin
						remaining_n   = remaining_q - LEN_W'(1);
						push          = 1'b1;
						push_cmd.data = in_ch.data;
						push_cmd.last = (remaining_q == LEN_W'(1));
						if (remaining_q == LEN_W'(1)) begin
							phase_n = PH_HIGH;
						end
					end
					default: begin
						phase_n = PH_HIGH;
					end
				endcase
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HIGH;
			len_hi_q    <= '0;
			remaining_q <= '0;
			violated_q  <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			len_hi_q    <= len_hi_n;
			remaining_q <= remaining_n;
			violated_q  <= violated_n;
		end
	end

	// Frame length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule

### rtl/lpd_queue.sv
// Short result queue between the front and the back parts.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_queue #(
	parameter int DEPTH = lpd_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lpd_pkg::lpd_cmd_t   push_cmd,
	input  logic                pop,
	output lpd_pkg::lpd_cmd_t   head_cmd,
	output lpd_pkg::lpd_qstat_t qstat
);
	import lpd_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lpd_cmd_t        entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_cmd    = entry_q[rd_ptr_q];

	// Entry storage; written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

### rtl/lpd_back.sv
// Back part: takes results from the queue and forms the output request
// in a registered output stage. Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lpd_pkg::lpd_qstat_t qstat,
	input  lpd_pkg::lpd_cmd_t   head_cmd,
	output logic                pop,
	lpd_out_if.source           out_ch
);
	import lpd_pkg::*;

	logic              valid_q;
	logic [BYTE_W-1:0] payload_q;
	logic              last_q;
	logic              error_q;

	// Load the output stage when it is empty or being drained.
	assign pop = !qstat.empty && (!valid_q || out_ch.ready);

	assign out_ch.valid   = valid_q;
	assign out_ch.payload = payload_q;
	assign out_ch.last    = last_q;
	assign out_ch.error   = error_q;

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload; an error result carries a zero byte and no last mark.
	always_ff @(posedge clk) begin
		if (pop) begin
			payload_q <= head_cmd.is_err ? '0 : head_cmd.data;
			last_q    <= head_cmd.last && !head_cmd.is_err;
			error_q   <= head_cmd.is_err;
		end
	end

endmodule

### rtl/length_prefix_deframer.sv
// Length prefix deframer: the result of an accepted byte is written into the
// result queue and then into the registered output stage. Throughput is one
// byte per cycle while the result queue has room, set by the front parse stage;
// the result queue holds QUEUE_DEPTH entries while the output stalls. Reset clears
// the parse state, the queue and the output stage, and sets the frame length limit to 65535.
`timescale 1ns / 1ps

module length_prefix_deframer #(
	parameter int QUEUE_DEPTH = lpd_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	lpd_in_if.sink                    in_ch,
	lpd_out_if.source                 out_ch,
	input  logic                      cfg_wr_en,
	input  logic [lpd_pkg::LEN_W-1:0] cfg_wr_data
);
	import lpd_pkg::*;

	lpd_qstat_t qstat;
	lpd_cmd_t   push_cmd;
	lpd_cmd_t   head_cmd;
	logic       push;
	logic       pop;

	// Parse and classify.
	lpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.qstat       (qstat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// Decoupling queue.
	lpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	// Output stage.
	lpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head_cmd (head_cmd),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule

### rtl/lpd_checker.sv
// Port-level checks of the length prefix deframer, bound to the top level.
// Depends on lpd_pkg and length_prefix_deframer_defines.svh.
`timescale 1ns / 1ps
`include "length_prefix_deframer_defines.svh"

module lpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lpd_pkg::BYTE_W-1:0] out_payload,
	input logic                       out_last,
	input logic                       out_error
);
	import lpd_pkg::*;

	// An error result never carries data or an end-of-frame mark.
	`LPD_ASSERT_IMPL(a_err_zero_payload, clk, arst_n, out_valid && out_error, out_payload == '0)
	`LPD_ASSERT_IMPL(a_err_not_last, clk, arst_n, out_valid && out_error, !out_last)

	// With the output stage empty the queue cannot be full.
	`LPD_ASSERT_IMPL(a_ready_when_drained, clk, arst_n, !out_valid, in_ready)

	// A stalled result stays offered and unchanged.
	`LPD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_payload) && $stable(out_last) && $stable(out_error))

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload),
	.out_last    (out_ch.last),
	.out_error   (out_ch.error)
);

### test/length_prefix_deframer_tb.sv
// Self-checking testbench for the length prefix deframer: a directed table, then random
// framed byte streams under several frame length limits, with random stalls on both sides.
// Depends on lpd_pkg, lpd_in_if, lpd_out_if and length_prefix_deframer.
`timescale 1ns / 1ps

module length_prefix_deframer_tb;
	import lpd_pkg::*;

	localparam int RAND_ITEMS  = 1100;
	localparam int PHASE_ITEMS = 110;
	localparam int DRAIN_WAIT  = 8;
	localparam int CYCLE_LIMIT = 600000;

	// One expected output request.
	typedef struct packed {
		logic [BYTE_W-1:0] payload;
		logic              last;
		logic              error;
	} frag_t;

	// Parser position of the predictor.
	typedef enum logic [2:0] {
		SEEK_HI = 3'b001,
		SEEK_LO = 3'b010,
		IN_BODY = 3'b100
	} parse_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct packed {
		row_kind_t         kind;
		logic              op;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  limit;
		logic              typed;
		logic              has_res;
		logic [BYTE_W-1:0] payload;
		logic              last;
		logic              error;
	} row_t;

	localparam int N_ROWS = 26;

	// Directed stimulus: restart, zero length, data extremes, the largest prefix,
	// restarts inside a prefix and inside a payload, and the oversize path at limit 0.
	localparam row_t DIR_ROWS [N_ROWS] = '{
		'{ROW_ITEM, OP_RESTART, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h01, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'hFF, 16'h0000, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h02, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h80, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'hFF, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'hFF, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h55, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'hAA, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_RESTART, 8'hFF, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h12, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_RESTART, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h01, 16'h0000, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_RESTART, 8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_ITEM, OP_BYTE,    8'h00, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{ROW_CFG,  OP_BYTE,    8'h00, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [LEN_W-1:0]      cfg_wr_data;

	lpd_in_if  in_ch ();
	lpd_out_if out_ch ();

	length_prefix_deframer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Predictor state and configuration.
	parse_t            ps;
	logic [BYTE_W-1:0] len_hi;
	logic [LEN_W-1:0]  remaining;
	logic              violated;
	logic [LEN_W-1:0]  max_len;

	frag_t pending_frags [$];

	int err_count;
	int fed_count;
	int restart_count;
	int byte_results;
	int oversize_results;
	int limit_writes;
	int idle_pct;
	int stall_left;
	int cycle_cnt;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the deframer state by one request; returns 1 when it yields a result.
	function automatic bit deframe_step(input logic op, input logic [BYTE_W-1:0] b,
			output frag_t res);
		logic [LEN_W-1:0] len;
		res = '0;
		if (op == OP_RESTART) begin
			ps = SEEK_HI;
			len_hi = '0;
			remaining = '0;
			violated = 1'b0;
			return 1'b0;
		end
		if (violated) begin
			return 1'b0;
		end
		unique case (ps)
			SEEK_LO: begin
				len = {len_hi, b};
				if (len > max_len) begin
					violated = 1'b1;
					ps = SEEK_HI;
					remaining = '0;
					res.error = 1'b1;
					return 1'b1;
				end
				remaining = len;
				ps = (len == '0) ? SEEK_HI : IN_BODY;
				return 1'b0;
			end
			IN_BODY: begin
				remaining = remaining - 16'd1;
				res.payload = b;
				res.last = (remaining == '0);
				if (remaining == '0) begin
					ps = SEEK_HI;
				end
				return 1'b1;
			end
			default: begin
				len_hi = b;
				ps = SEEK_LO;
				return 1'b0;
			end
		endcase
	endfunction

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) >= idle_pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(5, 30);
		end
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [LEN_W-1:0] pick_limit();
		case ($urandom_range(0, 7)) inside
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 8));
			[3:4]: return 16'($urandom_range(9, 40));
			5: return 16'($urandom_range(250, 260));
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one request, waits for its handshake and records what it should produce.
	task automatic push_req(input logic op, input logic [BYTE_W-1:0] d, input bit typed,
			input bit t_has, input frag_t t_res);
		int    g;
		bit    has;
		frag_t res;
		g = pick_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.data <= d;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (op == OP_RESTART) begin
			restart_count++;
		end
		if (op == OP_RESTART || !violated) begin
			fed_count++;
		end
		has = deframe_step(op, d, res);
		if (typed && (has != t_has || (has && res != t_res))) begin
			err_count++;
			$display("%t: table row disagrees with predictor: expected %0d/%h actual %0d/%h",
				$time, t_has, t_res, has, res);
		end
		if (typed) begin
			has = t_has;
			res = t_res;
		end
		if (has) begin
			pending_frags.push_back(res);
		end
	endtask

	task automatic feed(input logic op, input logic [BYTE_W-1:0] d);
		push_req(op, d, 1'b0, 1'b0, '0);
	endtask

	// Changes the limit once the block has drained; the stream itself may be mid-frame.
	task automatic write_limit(input logic [LEN_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (pending_frags.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len = v;
		limit_writes++;
	endtask

	// One frame with random content, or a burst of noise, or a broken frame.
	task automatic gen_frame();
		int               r;
		int               n;
		int               cut;
		logic [LEN_W-1:0] len;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			n = $urandom_range(1, 6);
			repeat (n) feed(($urandom_range(0, 4) == 0) ? OP_RESTART : OP_BYTE, 8'($urandom));
			return;
		end
		if (violated || ps != SEEK_HI) begin
			feed(OP_RESTART, 8'($urandom));
		end
		if (r < 60) begin
			len = 16'($urandom_range(0, 24));
		end else if (r < 78) begin
			len = max_len + 16'($urandom_range(0, 1));
		end else if (r < 80) begin
			len = 16'($urandom_range(25, 300));
		end else begin
			len = 16'($urandom);
		end
		feed(OP_BYTE, len[15:8]);
		// Restart between the two prefix bytes.
		if ($urandom_range(0, 24) == 0) begin
			feed(OP_RESTART, 8'($urandom));
			return;
		end
		feed(OP_BYTE, len[7:0]);
		// Oversized: a few bytes that must be dropped, then a restart.
		if (violated) begin
			repeat ($urandom_range(0, 4)) feed(OP_BYTE, 8'($urandom));
			feed(OP_RESTART, 8'($urandom));
			return;
		end
		n = (len > 16'd300) ? $urandom_range(0, 40) : int'(len);
		cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n) : n;
		for (int i = 0; i < cut; i++) begin
			feed(OP_BYTE, 8'($urandom));
		end
		if (cut < int'(len)) begin
			feed(OP_RESTART, 8'($urandom));
		end
	endtask

	// Output side: random stalls, with the same idling level as the input side.
	always @(posedge clk) begin : sink_ready
		int g;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			g = pick_gap();
			out_ch.ready <= (g == 0);
			stall_left <= (g > 0) ? g - 1 : 0;
		end
	end

	// Every accepted output request is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		frag_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_frags.size() == 0) begin
				err_count++;
				$display("%t: unexpected result: expected none actual payload=%h last=%b error=%b",
					$time, out_ch.payload, out_ch.last, out_ch.error);
			end else begin
				want = pending_frags.pop_front();
				if (out_ch.payload !== want.payload) begin
					err_count++;
					$display("%t: payload mismatch: expected %h actual %h",
						$time, want.payload, out_ch.payload);
				end
				if (out_ch.last !== want.last) begin
					err_count++;
					$display("%t: last mismatch: expected %b actual %b",
						$time, want.last, out_ch.last);
				end
				if (out_ch.error !== want.error) begin
					err_count++;
					$display("%t: error mismatch: expected %b actual %b",
						$time, want.error, out_ch.error);
				end
				if (want.error) begin
					oversize_results++;
				end else begin
					byte_results++;
				end
			end
		end
	end

	// Watchdog on the total cycle count.
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%t: timeout with %0d results outstanding", $time, pending_frags.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		row_t  row;
		frag_t typed_res;
		int    dir_fed;
		int    phase_start;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_BYTE;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		ps = SEEK_HI;
		len_hi = '0;
		remaining = '0;
		violated = 1'b0;
		max_len = MAX_LEN_RST;
		err_count = 0;
		fed_count = 0;
		restart_count = 0;
		byte_results = 0;
		oversize_results = 0;
		limit_writes = 0;
		idle_pct = 25;
		stall_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (int i = 0; i < N_ROWS; i++) begin
			row = DIR_ROWS[i];
			if (row.kind == ROW_CFG) begin
				write_limit(row.limit);
			end else begin
				typed_res.payload = row.payload;
				typed_res.last = row.last;
				typed_res.error = row.error;
				push_req(row.op, row.data, row.typed, row.has_res, typed_res);
			end
		end
		dir_fed = fed_count;

		// Random phases, each under a fresh limit and idling level.
		while (fed_count - dir_fed < RAND_ITEMS) begin
			write_limit(pick_limit());
			case ($urandom_range(0, 3))
				0: idle_pct = 0;
				1: idle_pct = 10;
				2: idle_pct = 30;
				default: idle_pct = 60;
			endcase
			phase_start = fed_count;
			while (fed_count - phase_start < PHASE_ITEMS) begin
				gen_frame();
			end
		end

		// Let the last results drain.
		in_ch.valid <= 1'b0;
		while (pending_frags.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d effective requests (%0d restarts) under %0d limit settings.",
			fed_count, restart_count, limit_writes);
		$display("Checked %0d payload bytes and %0d oversize reports.",
			byte_results, oversize_results);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
